FILE: hw/rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and arithmetic helpers for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int VAL_W           = 32;
	localparam int NUM_W           = 31;
	localparam int FRAC_W          = 16;
	localparam int MAG_W           = VAL_W + FRAC_W;   // wide magnitude before saturation
	localparam int DIV_STEPS       = MAG_W;            // one quotient bit per step
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_OP   = 2'd1,
		KIND_END  = 2'd2
	} pse_kind_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} pse_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNF   = 2'd1,
		ST_OVF   = 2'd2,
		ST_DIVZ  = 2'd3
	} pse_status_t;

	typedef enum logic [1:0] {
		SEL_TOP = 2'd0,
		SEL_NUM = 2'd1,
		SEL_RES = 2'd2
	} pse_sel_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_DECODE = 3'd1,
		S_EXEC   = 3'd2,
		S_MUL    = 3'd3,
		S_DIV    = 3'd4,
		S_FIN    = 3'd5
	} pse_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic        latch;      // capture the incoming number
		logic        push;       // push the captured number
		logic        clear;      // end of expression: empty the stack
		logic        rd;         // read the entry under the top
		logic        addsub_ld;  // add or subtract into result register
		logic        sub;        // subtract instead of add
		logic        mul_ld;     // register the magnitude product
		logic        mul_fin;    // saturate the product into result register
		logic        div_start;  // launch the iterative divide
		logic        div_ld;     // saturate the quotient into result register
		logic        pop_wb;     // drop one entry, result becomes top
		logic        out_ld;     // load the output register
		pse_sel_t    out_sel;
		pse_status_t out_status;
		logic        out_final;
	} pse_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;
		logic lt2;
		logic full;
		logic top_zero;
		logic out_free;
		logic div_done;
	} pse_sts_t;

	// magnitude of a signed Q16.16 value
	function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
		mag32 = x[VAL_W-1] ? (~x + 1'b1) : x;
	endfunction

	// apply sign to a wide magnitude and clamp to the Q16.16 range
	function automatic logic signed [VAL_W-1:0] sat_signmag(input logic neg,
			input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] lim;
		lim = MAG_W'(1) << (VAL_W - 1);
		if (neg) begin
			if (mag >= lim)
				sat_signmag = {1'b1, {(VAL_W-1){1'b0}}};
			else
				sat_signmag = ~mag[VAL_W-1:0] + 1'b1;
		end else begin
			if (mag >= lim)
				sat_signmag = {1'b0, {(VAL_W-1){1'b1}}};
			else
				sat_signmag = mag[VAL_W-1:0];
		end
	endfunction

	// clamp a one-bit-grown sum to the Q16.16 range
	function automatic logic signed [VAL_W-1:0] sat_sum(input logic signed [VAL_W:0] s);
		if (s[VAL_W] != s[VAL_W-1])
			sat_sum = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		else
			sat_sum = s[VAL_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/pse_div.sv
// ----------------------------------------------------------------------------
// pse_div
// Restoring divider, one quotient bit per cycle, for the Q16.16 divide.
// ----------------------------------------------------------------------------
module pse_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pse_pkg::MAG_W-1:0]      dividend,
	input  logic [pse_pkg::VAL_W-1:0]      divisor,
	output logic                           done,
	output logic [pse_pkg::MAG_W-1:0]      quotient
);
	import pse_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0]     dvd_q;
	logic [VAL_W:0]       rem_q;
	logic [VAL_W-1:0]     dsr_q;
	logic [VAL_W:0]       rem_sh;
	logic [VAL_W+1:0]     diff;
	logic                 qbit;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh = {rem_q[VAL_W-1:0], dvd_q[MAG_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
		qbit   = ~diff[VAL_W+1];
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[MAG_W-2:0], qbit};
			rem_q <= qbit ? diff[VAL_W:0] : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: hw/rtl/pse_dpath.sv
// ----------------------------------------------------------------------------
// pse_dpath
// Operand stack, top register, arithmetic units and output register.
// ----------------------------------------------------------------------------
module pse_dpath #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pse_pkg::pse_cmd_t                 cmd,
	output pse_pkg::pse_sts_t                 sts,
	input  logic [pse_pkg::NUM_W-1:0]         number_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pse_pkg::VAL_W-1:0]  top_value,
	output logic [1:0]                        status,
	output logic                              is_final
);
	import pse_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	// entries below the top live in memory, the top in a register
	logic [VAL_W-1:0]        mem [STACK_DEPTH];
	logic [DW-1:0]           depth_q;
	logic signed [VAL_W-1:0] top_q;
	logic signed [VAL_W-1:0] second_q;
	logic [NUM_W-1:0]        num_q;
	logic signed [VAL_W-1:0] res_q;
	logic [2*VAL_W-1:0]      prod_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_top_q;
	logic [1:0]              out_status_q;
	logic                    out_final_q;

	logic [AW-1:0]           wr_addr;
	logic [AW-1:0]           rd_addr;
	logic                    empty;
	logic                    neg;
	logic signed [VAL_W:0]   sum;
	logic [MAG_W-1:0]        quot;
	logic                    div_done;
	logic signed [VAL_W-1:0] cur_top;
	logic signed [VAL_W-1:0] out_mux;

	assign empty   = (depth_q == '0);
	assign wr_addr = AW'(depth_q - DW'(1));
	assign rd_addr = AW'(depth_q - DW'(2));
	assign neg     = second_q[VAL_W-1] ^ top_q[VAL_W-1];
	assign cur_top = empty ? '0 : top_q;

	always_comb begin
		if (cmd.sub)
			sum = {second_q[VAL_W-1], second_q} - {top_q[VAL_W-1], top_q};
		else
			sum = {second_q[VAL_W-1], second_q} + {top_q[VAL_W-1], top_q};
	end

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({mag32(second_q), {FRAC_W{1'b0}}}),
		.divisor  (mag32(top_q)),
		.done     (div_done),
		.quotient (quot)
	);

	// stack memory: spill the old top on push, fetch the left operand
	always_ff @(posedge clk) begin
		if (cmd.push && !empty)
			mem[wr_addr] <= top_q;
		if (cmd.rd)
			second_q <= mem[rd_addr];
	end

	// stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			depth_q <= '0;
		else if (cmd.clear)
			depth_q <= '0;
		else if (cmd.push)
			depth_q <= depth_q + DW'(1);
		else if (cmd.pop_wb)
			depth_q <= depth_q - DW'(1);
	end

	// top, captured number and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.latch)
			num_q <= number_value;
		if (cmd.push)
			top_q <= VAL_W'(num_q);
		else if (cmd.pop_wb)
			top_q <= res_q;
		if (cmd.mul_ld)
			prod_q <= (2*VAL_W)'(mag32(second_q)) * (2*VAL_W)'(mag32(top_q));
		if (cmd.addsub_ld)
			res_q <= sat_sum(sum);
		else if (cmd.mul_fin)
			res_q <= sat_signmag(neg, prod_q[2*VAL_W-1:FRAC_W]);
		else if (cmd.div_ld)
			res_q <= sat_signmag(neg, quot);
	end

	always_comb begin
		case (cmd.out_sel)
			SEL_NUM: out_mux = VAL_W'(num_q);
			SEL_RES: out_mux = res_q;
			default: out_mux = cur_top;
		endcase
	end

	// output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_ld)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_top_q    <= out_mux;
			out_status_q <= cmd.out_status;
			out_final_q  <= cmd.out_final;
		end
	end

	assign sts.empty    = empty;
	assign sts.lt2      = (depth_q < DW'(2));
	assign sts.full     = (depth_q == DW'(STACK_DEPTH));
	assign sts.top_zero = (top_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.div_done = div_done;

	assign out_valid = out_valid_q;
	assign top_value = out_top_q;
	assign status    = out_status_q;
	assign is_final  = out_final_q;

endmodule

FILE: hw/rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Token sequencer: decodes each token and steps the datapath through it.
// ----------------------------------------------------------------------------
module pse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [1:0]         operator_code,
	input  pse_pkg::pse_sts_t  sts,
	output pse_pkg::pse_cmd_t  cmd
);
	import pse_pkg::*;

	pse_state_t state_q;
	pse_state_t state_d;
	pse_kind_t  kind_q;
	pse_op_t    op_q;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// capture token kind and operator
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= pse_kind_t'(req_type);
			op_q   <= pse_op_t'(operator_code);
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.out_sel    = SEL_TOP;
		cmd.out_status = ST_OK;
		cmd.sub        = (op_q == OP_SUB);
		case (state_q)
			S_IDLE: begin
				cmd.latch = accept;
				if (accept)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				if (sts.out_free) begin
					case (kind_q)
						KIND_PUSH: begin
							cmd.out_ld = 1'b1;
							if (sts.full) begin
								cmd.out_status = ST_OVF;
							end else begin
								cmd.push    = 1'b1;
								cmd.out_sel = SEL_NUM;
							end
							state_d = S_IDLE;
						end
						KIND_OP: begin
							if (sts.lt2) begin
								cmd.out_ld     = 1'b1;
								cmd.out_status = ST_UNF;
								state_d        = S_IDLE;
							end else if (op_q == OP_DIV && sts.top_zero) begin
								cmd.out_ld     = 1'b1;
								cmd.out_status = ST_DIVZ;
								state_d        = S_IDLE;
							end else begin
								cmd.rd  = 1'b1;
								state_d = S_EXEC;
							end
						end
						KIND_END: begin
							cmd.out_ld     = 1'b1;
							cmd.out_final  = 1'b1;
							cmd.clear      = 1'b1;
							cmd.out_status = sts.empty ? ST_UNF : ST_OK;
							state_d        = S_IDLE;
						end
						default: begin
							cmd.out_ld = 1'b1;
							state_d    = S_IDLE;
						end
					endcase
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_MUL: begin
						cmd.mul_ld = 1'b1;
						state_d    = S_MUL;
					end
					OP_DIV: begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
					default: begin
						cmd.addsub_ld = 1'b1;
						state_d       = S_FIN;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul_fin = 1'b1;
				state_d     = S_FIN;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_ld = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				// write back the result once the output register can take it
				if (sts.out_free) begin
					cmd.pop_wb  = 1'b1;
					cmd.out_ld  = 1'b1;
					cmd.out_sel = SEL_RES;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Push, end and unused tokens and operator errors answer from decode; add and
// subtract step through execute and finish, multiply and the 48-step divide
// also through their own state. One token at a time: the next token is taken
// the cycle after the result is loaded. Reset empties the stack at once;
// stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [pse_pkg::NUM_W-1:0]         number_value,
	input  logic [1:0]                        operator_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pse_pkg::VAL_W-1:0]  top_value,
	output logic [1:0]                        status,
	output logic                              is_final
);
	import pse_pkg::*;

	pse_cmd_t cmd;
	pse_sts_t sts;

	pse_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.operator_code (operator_code),
		.sts           (sts),
		.cmd           (cmd)
	);

	pse_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.number_value (number_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.top_value    (top_value),
		.status       (status),
		.is_final     (is_final)
	);

	// a beat taken in means the sequencer is busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted beat");

	// an end on an empty stack reports zero
	a_final_unf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_final && status == ST_UNF) |-> (top_value == '0))
		else $error("empty end token reported a nonzero value");

	// a zero divisor stays on top, so the reported top is zero
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DIVZ) |-> (top_value == '0 && !is_final))
		else $error("divide by zero reported a nonzero top");

	// end tokens never report overflow or divide by zero
	a_final_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_final) |-> (status == ST_OK || status == ST_UNF))
		else $error("bad status on an end token");

endmodule

FILE: verif/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Watches both channels of the postfix stack evaluator. It runs its own
// operand stack on every accepted token beat, queues the expected result and
// compares each accepted result beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module pse_checker #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [pse_pkg::NUM_W-1:0]         number_value,
	input  logic [1:0]                        operator_code,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [pse_pkg::VAL_W-1:0]  top_value,
	input  logic [1:0]                        status,
	input  logic                              is_final,
	output int                                mismatches,
	output int                                pending,
	output int                                tokens,
	output int                                results,
	output int                                finals,
	output int                                underflows,
	output int                                overflows,
	output int                                div_zeros
);
	import pse_pkg::*;

	localparam int MAX_REPORTS = 50;

	typedef struct {
		logic signed [VAL_W-1:0] top;
		pse_status_t             st;
		logic                    fin;
	} token_result_t;

	logic signed [VAL_W-1:0] model_stack [STACK_DEPTH];
	int                      model_depth;
	token_result_t           expected_results [$];

	// magnitude of a signed 64-bit value
	function automatic longint unsigned abs_wide(input longint x);
		return (x < 0) ? longint'(-x) : x;
	endfunction

	// sign a magnitude and clamp it to Q16.16
	function automatic logic signed [VAL_W-1:0] clamp_q(input logic neg,
			input longint unsigned mag);
		if (neg)
			return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : VAL_W'(64'd0 - mag);
		return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : VAL_W'(mag);
	endfunction

	// apply one token to the model stack and return the result it gives
	function automatic token_result_t evaluate_token(input logic [1:0] kind,
			input logic [NUM_W-1:0] num, input logic [1:0] op);
		token_result_t res;
		longint lhs, rhs, sum;
		logic signed [VAL_W-1:0] value;
		logic neg;
		res.top = '0;
		res.st  = ST_OK;
		res.fin = 1'b0;
		value   = '0;
		case (kind)
		KIND_PUSH: begin
			if (model_depth >= STACK_DEPTH) begin
				res.st = ST_OVF;
			end else begin
				model_stack[model_depth] = {1'b0, num};
				model_depth++;
			end
		end
		KIND_OP: begin
			if (model_depth < 2) begin
				res.st = ST_UNF;
			end else begin
				rhs = model_stack[model_depth-1];
				lhs = model_stack[model_depth-2];
				neg = (lhs < 0) != (rhs < 0);
				case (op)
				OP_ADD: begin
					sum   = lhs + rhs;
					value = clamp_q(sum < 0, abs_wide(sum));
				end
				OP_SUB: begin
					sum   = lhs - rhs;
					value = clamp_q(sum < 0, abs_wide(sum));
				end
				OP_MUL: value = clamp_q(neg, (abs_wide(lhs) * abs_wide(rhs)) >> FRAC_W);
				default: begin
					if (rhs == 0)
						res.st = ST_DIVZ;
					else
						value = clamp_q(neg, (abs_wide(lhs) << FRAC_W) / abs_wide(rhs));
				end
				endcase
				// collapse two entries into the result
				if (res.st == ST_OK) begin
					model_depth--;
					model_stack[model_depth-1] = value;
				end
			end
		end
		KIND_END: begin
			res.fin = 1'b1;
			if (model_depth == 0)
				res.st = ST_UNF;
			else
				res.top = model_stack[model_depth-1];
			model_depth = 0;
		end
		default: ;
		endcase
		if (kind != KIND_END)
			res.top = (model_depth == 0) ? '0 : model_stack[model_depth-1];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch on %s at result %0d: got %h, expected %h",
				$time, what, results, got, want);
	endtask

	// check result beats first, then predict from the token beat
	always @(posedge clk or negedge arst_n) begin
		token_result_t want;
		if (!arst_n) begin
			model_depth = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results++;
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing pending", top_value, '0);
				end else begin
					want = expected_results.pop_front();
					if (top_value !== want.top)
						report_mismatch("top_value", top_value, want.top);
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (is_final !== want.fin)
						report_mismatch("is_final", 32'(is_final), 32'(want.fin));
				end
			end
			if (in_valid && !in_stall) begin
				tokens++;
				want = evaluate_token(req_type, number_value, operator_code);
				if (want.fin)
					finals++;
				case (want.st)
				ST_UNF:  underflows++;
				ST_OVF:  overflows++;
				ST_DIVZ: div_zeros++;
				default: ;
				endcase
				expected_results.push_back(want);
			end
			pending = expected_results.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives token beats into the postfix stack evaluator: a directed pass over
// saturation, underflow, divide by zero and end handling, then random
// well-formed expressions, deep stack fills and noise, with random idle
// and stall bursts. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import pse_pkg::*;

	localparam int               RANDOM_ITEMS = 1450;
	localparam int               CALM_ITEMS   = 200;
	localparam int               CYCLE_LIMIT  = 1_000_000;
	localparam int               DRAIN_CYCLES = 64;
	localparam logic [1:0]       KIND_SPARE   = 2'd3;     // request code that leaves the stack unchanged
	localparam logic [NUM_W-1:0] NUM_MAX      = '1;
	localparam logic [NUM_W-1:0] Q_TWO        = 31'h0002_0000;
	localparam logic [NUM_W-1:0] Q_THREE      = 31'h0003_0000;
	localparam logic [NUM_W-1:0] Q_TINY       = 31'h0000_0001;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_stall;
	logic [1:0]                req_type      = '0;
	logic [NUM_W-1:0]          number_value  = '0;
	logic [1:0]                operator_code = '0;
	logic                      out_valid;
	logic                      out_stall     = 1'b0;
	logic signed [VAL_W-1:0]   top_value;
	logic [1:0]                status;
	logic                      is_final;

	int mismatches, pending, tokens, results, finals, underflows, overflows, div_zeros;
	int cycles;
	int items_sent;
	int stall_burst;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	postfix_stack_evaluator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.number_value  (number_value),
		.operator_code (operator_code),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.top_value     (top_value),
		.status        (status),
		.is_final      (is_final)
	);

	pse_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.number_value  (number_value),
		.operator_code (operator_code),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.top_value     (top_value),
		.status        (status),
		.is_final      (is_final),
		.mismatches    (mismatches),
		.pending       (pending),
		.tokens        (tokens),
		.results       (results),
		.finals        (finals),
		.underflows    (underflows),
		.overflows     (overflows),
		.div_zeros     (div_zeros)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// end the run once the cycle limit is reached
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// hold off result beats in random bursts
	always @(negedge clk) begin
		if (stall_burst > 0) begin
			out_stall <= 1'b1;
			stall_burst--;
		end else if (rx_idle && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_burst = $urandom_range(0, 9);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [NUM_W-1:0] pick_number();
		case ($urandom_range(0, 9))
		0:       return '0;
		1:       return NUM_MAX;
		2, 3, 4: return NUM_W'($urandom_range(0, 32'h0004_0000));
		5:       return NUM_W'($urandom_range(1, 255)) << FRAC_W;
		default: return NUM_W'($urandom());
		endcase
	endfunction

	function automatic logic [1:0] pick_op();
		return 2'($urandom_range(0, 3));
	endfunction

	// present one token beat and wait until it is taken
	task automatic send_token(input logic [1:0] kind, input logic [NUM_W-1:0] num,
			input logic [1:0] op);
		@(negedge clk);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= kind;
		number_value  <= num;
		operator_code <= op;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (kind != KIND_SPARE)
			items_sent++;
	endtask

	// push and combine so the stack never runs short, then optionally close
	task automatic send_expression(input int operands, input bit close);
		int left, depth;
		left  = operands;
		depth = 0;
		while (left > 0 || depth > 1) begin
			if (depth < 2 || (left > 0 && $urandom_range(0, 1) == 1)) begin
				send_token(KIND_PUSH, pick_number(), pick_op());
				left--;
				depth++;
			end else begin
				send_token(KIND_OP, pick_number(), pick_op());
				depth--;
			end
		end
		if (close)
			send_token(KIND_END, pick_number(), pick_op());
	endtask

	initial begin
		int start, choice;
		bit calm;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// empty and short stack errors
		send_token(KIND_OP, '0, OP_ADD);
		send_token(KIND_END, NUM_MAX, OP_DIV);
		send_token(KIND_PUSH, NUM_MAX, OP_ADD);
		send_token(KIND_OP, '0, OP_MUL);
		// positive saturation on add, multiply and divide
		send_token(KIND_PUSH, NUM_MAX, OP_ADD);
		send_token(KIND_OP, '0, OP_ADD);
		send_token(KIND_PUSH, '0, OP_ADD);
		send_token(KIND_OP, '0, OP_DIV);
		send_token(KIND_OP, '0, OP_SUB);
		send_token(KIND_PUSH, NUM_MAX, OP_ADD);
		send_token(KIND_OP, '0, OP_MUL);
		send_token(KIND_PUSH, Q_TINY, OP_ADD);
		send_token(KIND_OP, '0, OP_DIV);
		send_token(KIND_END, '0, OP_ADD);
		// negative values and negative saturation
		send_token(KIND_PUSH, '0, OP_ADD);
		send_token(KIND_PUSH, NUM_MAX, OP_ADD);
		send_token(KIND_OP, '0, OP_SUB);
		send_token(KIND_PUSH, NUM_MAX, OP_ADD);
		send_token(KIND_OP, '0, OP_SUB);
		send_token(KIND_PUSH, Q_THREE, OP_ADD);
		send_token(KIND_OP, '0, OP_MUL);
		send_token(KIND_PUSH, Q_TWO, OP_ADD);
		send_token(KIND_OP, '0, OP_DIV);
		send_token(KIND_SPARE, NUM_MAX, OP_DIV);
		send_token(KIND_END, '0, OP_ADD);

		// random expressions, stack fills and noise; no idling near the end
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			calm    = (items_sent - start) > (RANDOM_ITEMS - CALM_ITEMS);
			tx_idle = !calm && $urandom_range(0, 4) != 0;
			rx_idle = !calm && $urandom_range(0, 4) != 0;
			choice  = $urandom_range(0, 19);
			if (choice < 14) begin
				send_expression($urandom_range(1, 8), $urandom_range(0, 9) != 0);
			end else if (choice < 16) begin
				repeat ($urandom_range(28, 36))
					send_token(KIND_PUSH, pick_number(), pick_op());
				repeat ($urandom_range(0, 40))
					send_token(KIND_OP, pick_number(), pick_op());
				send_token(KIND_END, pick_number(), pick_op());
			end else begin
				repeat ($urandom_range(1, 6))
					send_token(2'($urandom_range(0, 3)), NUM_W'($urandom()), pick_op());
			end
		end

		// drain and settle
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d tokens into %0d checked results over %0d cycles", tokens, results,
			cycles);
		$display("Outcomes: %0d final, %0d underflow, %0d overflow, %0d divide by zero",
			finals, underflows, overflows, div_zeros);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
